/* design/prrts_pkg.sv */
// Package: shared types, constants and codes for the task scheduler.
`default_nettype none
package prrts_pkg;
	localparam int MAX_TASKS_DEF = 16;
	localparam int PRIO_BITS_DEF = 8;
	localparam int TICK_BITS_DEF = 32;
	localparam int CMD_W = 3;
	localparam int SLOT_W = 4;
	localparam int PRIN_W = 8;
	localparam int DLY_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_ACTIVATE = 3'd1,
		CMD_TERMINATE = 3'd2,
		CMD_DELAY = 3'd3,
		CMD_TICK = 3'd4,
		CMD_START = 3'd5,
		CMD_RSVD6 = 3'd6,
		CMD_RSVD7 = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SUSPEND = 2'd0,
		ST_READY = 2'd1,
		ST_WAITING = 2'd2,
		ST_RUNNING = 2'd3
	} tstate_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK = 2'd0,
		STAT_BAD_PRIO = 2'd1,
		STAT_FULL = 2'd2,
		STAT_RSVD = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWEST = 1'd1;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_TICK,
		SQ_SCAN_MIN,
		SQ_SCAN_PUSH,
		SQ_DECIDE,
		SQ_DECIDE2,
		SQ_DONE
	} seq_state_t;
endpackage
`default_nettype wire

/* design/prrts_if.sv */
// Interfaces: command and result channels with valid/ready handshake.
`default_nettype none
interface prrts_cmd_if;
	import prrts_pkg::*;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [SLOT_W-1:0] task_slot;
	logic [PRIN_W-1:0] task_priority_in;
	logic [DLY_W-1:0] delay_ticks;
	modport source (output valid, cmd, task_slot, task_priority_in, delay_ticks, input ready);
	modport sink (input valid, cmd, task_slot, task_priority_in, delay_ticks, output ready);
endinterface

interface prrts_res_if;
	import prrts_pkg::*;
	logic valid;
	logic ready;
	logic [SLOT_W-1:0] next_task;
	logic switch_request;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0] ready_count;
	modport source (output valid, next_task, switch_request, status, ready_count, input ready);
	modport sink (input valid, next_task, switch_request, status, ready_count, output ready);
endinterface
`default_nettype wire

/* design/priority_round_robin_task_scheduler.sv */
// Top level: task table, ready queue and slot-walking sequencer of the scheduler.
//
// channel | dir | handshake   | payload
// cmd_ch  | in  | valid/ready | cmd, task_slot, task_priority_in, delay_ticks
// res_ch  | out | valid/ready | next_task, switch_request, status, ready_count
// cfg     | in  | cfg_we      | cfg_idx, cfg_data
//
// A create, an unknown command or one on an uncreated slot goes from idle to
// done; a tick with a wake, once started, rebuilds and decides: the sequencer walks
// one table slot per cycle through the shared compare unit, once for the tick
// countdown, once for the best priority, once for the enqueue pass; deciding takes
// one or two more states (decide, decide2). The block is ready only while idle;
// a finished command holds in done while the previous result still waits in the
// output register. Reset clears control state and valid bits, so no clearing pass.
`default_nettype none
module priority_round_robin_task_scheduler
	import prrts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int PRIO_BITS = PRIO_BITS_DEF,
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	prrts_cmd_if.sink cmd_ch,
	prrts_res_if.source res_ch,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int TW = $clog2(MAX_TASKS + 1);
	localparam int SW = TW + 1;

	// task table and queue storage
	logic [PRIO_BITS-1:0] prio_q [MAX_TASKS];
	tstate_t st_q [MAX_TASKS];
	logic blk_q [MAX_TASKS];
	logic [TICK_BITS-1:0] ticks_q [MAX_TASKS];
	logic [IW-1:0] fifo_q [MAX_TASKS];
	logic [IW-1:0] head_q;
	logic [TW-1:0] fill_q;
	logic [TW-1:0] total_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] nxt_q;
	logic running_q;
	logic [7:0] hi_q, lo_q;

	// command latch and sequencer
	seq_state_t sq_q, sq_d;
	cmd_t cmd_q;
	logic [TW-1:0] i_q;
	logic [8:0] best_q;
	logic woke_q;
	logic [STAT_W-1:0] stat_q;
	logic sw_q;

	// output register
	logic rvalid_q;
	logic [SLOT_W-1:0] res_next_q;
	logic res_sw_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic [IW-1:0] i_idx;
	logic [SW-1:0] pos_sum;
	logic [IW-1:0] pos;
	logic [IW-1:0] head_nx;
	logic [IW-1:0] popped;
	logic [IW-1:0] slot_in;
	logic acc;
	logic i_last;
	logic slot_ok;
	logic tick_wake;
	logic want_decide;
	logic keep_cur;
	logic res_load;

	assign i_idx = i_q[IW-1:0];
	assign acc = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (sq_q == SQ_IDLE);
	assign i_last = (i_q + TW'(1)) == total_q;
	assign pos_sum = SW'(head_q) + SW'(fill_q);
	assign pos = (pos_sum >= SW'(MAX_TASKS)) ? IW'(pos_sum - SW'(MAX_TASKS)) : IW'(pos_sum);
	assign head_nx = (head_q == IW'(MAX_TASKS - 1)) ? '0 : head_q + IW'(1);
	assign popped = fifo_q[head_q];
	assign slot_in = IW'(cmd_ch.task_slot);
	assign slot_ok = (SW'(cmd_ch.task_slot) < SW'(total_q))
		&& (int'(cmd_ch.task_slot) < MAX_TASKS);
	assign tick_wake = blk_q[i_idx] && (ticks_q[i_idx] == TICK_BITS'(2));
	assign want_decide = running_q && ((cmd_q == CMD_TICK) || (cur_q != '0));
	assign keep_cur = (fill_q == '0) && (st_q[cur_q] != ST_SUSPEND);
	assign res_load = (sq_q == SQ_DONE) && (!rvalid_q || res_ch.ready);

	// sequencer next state
	always_comb begin
		sq_d = sq_q;
		case (sq_q)
			SQ_IDLE: if (acc) begin
				case (cmd_t'(cmd_ch.cmd))
					CMD_TICK: sq_d = SQ_TICK;
					CMD_ACTIVATE, CMD_TERMINATE, CMD_DELAY:
						sq_d = slot_ok ? SQ_SCAN_MIN : SQ_DONE;
					CMD_START: sq_d = SQ_SCAN_MIN;
					default: sq_d = SQ_DONE;
				endcase
			end
			SQ_TICK: if (i_last)
				sq_d = (woke_q || tick_wake) ? SQ_SCAN_MIN
					: (want_decide ? SQ_DECIDE : SQ_DONE);
			SQ_SCAN_MIN: if (i_last) sq_d = SQ_SCAN_PUSH;
			SQ_SCAN_PUSH: if (i_last) sq_d = want_decide ? SQ_DECIDE : SQ_DONE;
			SQ_DECIDE: sq_d = keep_cur ? SQ_DONE : SQ_DECIDE2;
			SQ_DECIDE2: sq_d = SQ_DONE;
			SQ_DONE: if (!rvalid_q || res_ch.ready) sq_d = SQ_IDLE;
			default: sq_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_q <= SQ_IDLE;
		else sq_q <= sq_d;
	end

	// datapath: one slot per cycle through the shared compare unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				st_q[k] <= ST_SUSPEND;
				blk_q[k] <= 1'b0;
			end
			prio_q[0] <= PRIO_BITS'(8'd255);
			head_q <= '0;
			fill_q <= '0;
			total_q <= TW'(1);
			cur_q <= '0;
			nxt_q <= '0;
			running_q <= 1'b0;
			hi_q <= 8'd0;
			lo_q <= 8'd255;
			i_q <= '0;
			woke_q <= 1'b0;
			sw_q <= 1'b0;
			stat_q <= STAT_OK;
			best_q <= 9'h100;
			cmd_q <= CMD_RSVD7;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_HIGHEST) hi_q <= cfg_data;
				else begin
					lo_q <= cfg_data;
					prio_q[0] <= PRIO_BITS'(cfg_data);
				end
			end
			case (sq_q)
				SQ_IDLE: if (acc) begin
					cmd_q <= cmd_t'(cmd_ch.cmd);
					i_q <= '0;
					woke_q <= 1'b0;
					best_q <= 9'h100;
					sw_q <= 1'b0;
					stat_q <= STAT_OK;
					case (cmd_t'(cmd_ch.cmd))
						CMD_CREATE: begin
							if ((int'(cmd_ch.task_priority_in) >= (1 << PRIO_BITS))
								|| cmd_ch.task_priority_in < hi_q
								|| cmd_ch.task_priority_in > lo_q)
								stat_q <= STAT_BAD_PRIO;
							else if (total_q >= TW'(MAX_TASKS))
								stat_q <= STAT_FULL;
							else begin
								prio_q[total_q[IW-1:0]] <= PRIO_BITS'(cmd_ch.task_priority_in);
								st_q[total_q[IW-1:0]] <= ST_SUSPEND;
								blk_q[total_q[IW-1:0]] <= 1'b0;
								ticks_q[total_q[IW-1:0]] <= '0;
								total_q <= total_q + TW'(1);
							end
						end
						// apply the slot change before the rebuild
						CMD_ACTIVATE: if (slot_ok) st_q[slot_in] <= ST_WAITING;
						CMD_TERMINATE: if (slot_ok) st_q[slot_in] <= ST_SUSPEND;
						CMD_DELAY: if (slot_ok) begin
							st_q[slot_in] <= ST_SUSPEND;
							blk_q[slot_in] <= 1'b1;
							ticks_q[slot_in] <= TICK_BITS'(cmd_ch.delay_ticks);
						end
						CMD_START: begin
							running_q <= 1'b1;
							cur_q <= '0;
							st_q[0] <= ST_WAITING;
						end
						default: ;
					endcase
				end
				SQ_TICK: begin
					if (blk_q[i_idx]) begin
						ticks_q[i_idx] <= ticks_q[i_idx] - TICK_BITS'(1);
						if (tick_wake) begin
							st_q[i_idx] <= ST_WAITING;
							blk_q[i_idx] <= 1'b0;
							woke_q <= 1'b1;
						end
					end
					i_q <= i_last ? '0 : i_q + TW'(1);
				end
				SQ_SCAN_MIN: begin
					// empty the queue, then track the best priority
					if (i_q == '0) fill_q <= '0;
					if (st_q[i_idx] != ST_SUSPEND && 9'(prio_q[i_idx]) < best_q)
						best_q <= 9'(prio_q[i_idx]);
					i_q <= i_last ? '0 : i_q + TW'(1);
				end
				SQ_SCAN_PUSH: begin
					// enqueue every live task of the best priority in slot order
					if (st_q[i_idx] != ST_SUSPEND && 9'(prio_q[i_idx]) == best_q) begin
						if (fill_q < TW'(MAX_TASKS)) begin
							fifo_q[pos] <= i_idx;
							fill_q <= fill_q + TW'(1);
						end
						st_q[i_idx] <= ST_READY;
					end
					i_q <= i_last ? '0 : i_q + TW'(1);
				end
				SQ_DECIDE: begin
					sw_q <= 1'b1;
					if (keep_cur) begin
						// nothing queued: keep the current task running
						st_q[cur_q] <= ST_RUNNING;
						fifo_q[pos] <= cur_q;
						fill_q <= fill_q + TW'(1);
					end else if (fill_q != '0) begin
						nxt_q <= popped;
						head_q <= head_nx;
						fill_q <= fill_q - TW'(1);
						st_q[popped] <= ST_RUNNING;
					end else begin
						nxt_q <= '0;
						st_q[0] <= ST_RUNNING;
					end
				end
				SQ_DECIDE2: begin
					// re-queue the current task at equal priority for round robin
					if (prio_q[nxt_q] == prio_q[cur_q] && st_q[cur_q] != ST_SUSPEND) begin
						if (fill_q < TW'(MAX_TASKS)) begin
							fifo_q[pos] <= cur_q;
							fill_q <= fill_q + TW'(1);
						end
						st_q[cur_q] <= ST_READY;
					end
					cur_q <= nxt_q;
				end
				default: ;
			endcase
		end
	end

	// output register: load when the previous result is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			res_next_q <= '0;
			res_sw_q <= 1'b0;
			res_stat_q <= STAT_OK;
			res_cnt_q <= '0;
		end else if (res_load) begin
			rvalid_q <= 1'b1;
			res_next_q <= SLOT_W'(cur_q);
			res_sw_q <= sw_q;
			res_stat_q <= stat_q;
			res_cnt_q <= CNT_W'(fill_q);
		end else if (res_ch.valid && res_ch.ready) begin
			rvalid_q <= 1'b0;
		end
	end

	assign res_ch.valid = rvalid_q;
	assign res_ch.next_task = res_next_q;
	assign res_ch.switch_request = res_sw_q;
	assign res_ch.status = res_stat_q;
	assign res_ch.ready_count = res_cnt_q;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && !res_ch.ready |=> res_ch.valid
		&& $stable({res_ch.next_task, res_ch.switch_request, res_ch.status,
		res_ch.ready_count}))
		else $error("result changed while waiting");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q != SQ_IDLE |-> !cmd_ch.ready)
		else $error("ready while busy");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= TW'(MAX_TASKS))
		else $error("queue fill out of range");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q >= TW'(1) && total_q <= TW'(MAX_TASKS))
		else $error("task total out of range");
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		int'(head_q) < MAX_TASKS)
		else $error("queue head out of range");
endmodule
`default_nettype wire
